// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by the ring buffer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/frb_pkg.sv =====
// Types, constants and pointer helpers for the frame ring buffer.
package frb_pkg;

  localparam int MEM_DEPTH     = 4096;
  localparam int MAX_FRAME_LEN = 64;
  localparam int MAX_SLOTS     = 4096;

  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int DATA_W = 32;
  localparam int LEN_W  = $clog2(MAX_FRAME_LEN + 1);
  localparam int OFF_W  = $clog2(MAX_FRAME_LEN);
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int CAP_W  = $clog2(MAX_SLOTS + 1);

  // Configuration register indexes
  localparam logic CFG_FRAME_LEN = 1'b0;
  localparam logic CFG_CAPACITY  = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DROP  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  // Frame slot pointer: slot number and element base address
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] base;
  } ring_ptr_t;

  // Clamp the frame length register into 1..MAX_FRAME_LEN
  function automatic logic [LEN_W-1:0] eff_len(logic [LEN_W-1:0] len);
    if (len == '0) begin
      return LEN_W'(1);
    end else if (len > LEN_W'(MAX_FRAME_LEN)) begin
      return LEN_W'(MAX_FRAME_LEN);
    end
    return len;
  endfunction

  // Clamp the capacity register into 1..MAX_SLOTS
  function automatic logic [CAP_W-1:0] eff_cap(logic [CAP_W-1:0] cap);
    if (cap == '0) begin
      return CAP_W'(1);
    end else if (cap > CAP_W'(MAX_SLOTS)) begin
      return CAP_W'(MAX_SLOTS);
    end
    return cap;
  endfunction

  // Step a pointer to the next frame slot, wrapping at the capacity
  function automatic ring_ptr_t ring_advance(ring_ptr_t p, logic [LEN_W-1:0] len,
                                             logic [CAP_W-1:0] cap);
    ring_ptr_t        r;
    logic [CAP_W-1:0] nxt;
    nxt = CAP_W'(p.slot) + CAP_W'(1);
    if (nxt >= cap) begin
      r = '0;
    end else begin
      r.slot = nxt[SLOT_W-1:0];
      r.base = p.base + ADDR_W'(len);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/frb_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
module frb_ram #(
  parameter int AddrW = 12,
  parameter int DataW = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [2**AddrW];
  logic [DataW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/frame_ring_buffer_drop_oldest_unit.sv =====
// Top level of the frame ring buffer with drop-oldest overflow.
//
//  channel   handshake            payload
//  --------  -------------------  ---------------------------------------------
//  command   start, busy          command_i, sample_in_i
//  result    done_o (strobe)      status_o, sample_out_o, last_o,
//                                 frames_available_o
//  config    cfg_we_i             cfg_index_i, cfg_wdata_i
//
// Write, flush and empty read: the result beat follows in the cycle after
// start. A read with data gives frame_len samples, one sample per cycle out
// of the sample RAM read port while no config write comes in; busy is high
// for the rest of the frame. Result beats come the cycle after the RAM read.
// Reset clears all pointers and the frame count; sample RAM is not cleared.
// Results cannot be stalled: each beat stands for exactly one cycle.
`include "assert_macros.svh"

module frame_ring_buffer_drop_oldest_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                command_i,
  input  logic [frb_pkg::DATA_W-1:0] sample_in_i,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic [frb_pkg::DATA_W-1:0] sample_out_o,
  output logic                      last_o,
  output logic [frb_pkg::CAP_W-1:0] frames_available_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [frb_pkg::CAP_W-1:0] cfg_wdata_i
);
  import frb_pkg::*;

  state_e            state_q, state_d;
  logic [LEN_W-1:0]  len_q;
  logic [CAP_W-1:0]  cap_q;
  ring_ptr_t         wptr_q, wptr_d;
  ring_ptr_t         rptr_q, rptr_d;
  logic [OFF_W-1:0]  woff_q, woff_d;
  logic [CAP_W-1:0]  frames_q, frames_d, frames_tmp;
  logic [ADDR_W-1:0] rd_base_q, rd_base_d;
  logic [OFF_W-1:0]  idx_q, idx_d;

  logic              out_vld_q, out_vld_d;
  status_e           out_status_q, out_status_d;
  logic              out_last_q, out_last_d;
  logic              out_rsel_q, out_rsel_d;
  logic [CAP_W-1:0]  out_avail_q;

  logic [LEN_W-1:0]  len_eff;
  logic [CAP_W-1:0]  cap_eff;
  logic [LEN_W-1:0]  woff_inc;
  logic              accept, idx_last, read_go;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign len_eff  = eff_len(len_q);
  assign cap_eff  = eff_cap(cap_q);
  assign busy     = (state_q == ST_READ);
  assign accept   = start && !busy;
  assign idx_last = (LEN_W'(idx_q) == len_eff - LEN_W'(1));
  assign woff_inc = LEN_W'(woff_q) + LEN_W'(1);
  assign read_go  = accept && !cfg_we_i && (cmd_e'(command_i) == CMD_READ) &&
                    (frames_q != '0);

  // Sample RAM addressing
  assign ram_waddr = wptr_q.base + ADDR_W'(woff_q);
  assign ram_raddr = (state_q == ST_READ) ? rd_base_q + ADDR_W'(idx_q) : rptr_q.base;

  frb_ram #(
    .AddrW(ADDR_W),
    .DataW(DATA_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(sample_in_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (read_go && len_eff != LEN_W'(1)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (idx_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Pointer update and result beat preparation
  always_comb begin
    wptr_d       = wptr_q;
    rptr_d       = rptr_q;
    woff_d       = woff_q;
    frames_d     = frames_q;
    frames_tmp   = frames_q;
    rd_base_d    = rd_base_q;
    idx_d        = idx_q;
    ram_we       = 1'b0;
    out_vld_d    = 1'b0;
    out_status_d = STAT_OK;
    out_last_d   = 1'b1;
    out_rsel_d   = 1'b0;
    if (cfg_we_i) begin
      // geometry changes: drop everything
      wptr_d   = '0;
      rptr_d   = '0;
      woff_d   = '0;
      frames_d = '0;
    end else if (state_q == ST_READ) begin
      // stream the rest of the frame
      out_vld_d  = 1'b1;
      out_rsel_d = 1'b1;
      out_last_d = idx_last;
      idx_d      = idx_q + OFF_W'(1);
    end else if (accept) begin
      out_vld_d = 1'b1;
      unique case (cmd_e'(command_i))
        CMD_WRITE: begin
          if (woff_q == '0 && frames_q >= cap_eff) begin
            rptr_d       = ring_advance(rptr_q, len_eff, cap_eff);
            frames_tmp   = frames_q - CAP_W'(1);
            out_status_d = STAT_DROP;
          end
          ram_we = 1'b1;
          if (woff_inc >= len_eff) begin
            woff_d   = '0;
            wptr_d   = ring_advance(wptr_q, len_eff, cap_eff);
            frames_d = frames_tmp + CAP_W'(1);
          end else begin
            woff_d   = woff_inc[OFF_W-1:0];
            frames_d = frames_tmp;
          end
        end
        CMD_READ: begin
          if (frames_q == '0) begin
            out_status_d = STAT_EMPTY;
          end else begin
            rptr_d     = ring_advance(rptr_q, len_eff, cap_eff);
            frames_d   = frames_q - CAP_W'(1);
            rd_base_d  = rptr_q.base;
            idx_d      = OFF_W'(1);
            out_rsel_d = 1'b1;
            out_last_d = (len_eff == LEN_W'(1));
          end
        end
        CMD_FLUSH: begin
          wptr_d   = '0;
          rptr_d   = '0;
          woff_d   = '0;
          frames_d = '0;
        end
        default: begin
          // unused command: report the count, change nothing
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= LEN_W'(MAX_FRAME_LEN);
      cap_q     <= CAP_W'(64);
      wptr_q    <= '0;
      rptr_q    <= '0;
      woff_q    <= '0;
      frames_q  <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wptr_q    <= wptr_d;
      rptr_q    <= rptr_d;
      woff_q    <= woff_d;
      frames_q  <= frames_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FRAME_LEN: len_q <= cfg_wdata_i[LEN_W-1:0];
          CFG_CAPACITY:  cap_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Result beat payload
  always_ff @(posedge clk_i) begin
    rd_base_q    <= rd_base_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
    out_rsel_q   <= out_rsel_d;
    out_avail_q  <= frames_d;
  end

  // Drive outputs
  always_comb begin
    done_o             = out_vld_q;
    status_o           = out_status_q;
    last_o             = out_last_q;
    frames_available_o = out_avail_q;
    sample_out_o       = out_rsel_q ? ram_rdata : '0;
  end

  `ASSERT_IMPLIES(a_frames_within_cap, clk_i, rst_ni, 1'b1, frames_q <= cap_eff, "frame count above capacity")
  `ASSERT_IMPLIES(a_woff_within_len, clk_i, rst_ni, 1'b1, LEN_W'(woff_q) < len_eff, "write offset past frame end")
  `ASSERT_NEXT(a_read_beat, clk_i, rst_ni, state_q == ST_READ && !cfg_we_i, done_o && out_rsel_q, "read cycle gave no sample beat")

endmodule

// ===== tb/frame_ring_buffer_drop_oldest_unit_tb.sv =====
// Self-checking testbench for the frame ring buffer with drop-oldest overflow.
module frame_ring_buffer_drop_oldest_unit_tb;
  import frb_pkg::*;

  localparam logic [1:0] CMD_SPARE   = 2'd3;  // unused command code
  localparam int         STALL_LIMIT = 2000;  // cycles without an input or register beat
  localparam int         DRAIN_WAIT  = 70;    // covers the longest frame read

  typedef struct {
    logic [1:0]        cmd;
    logic [DATA_W-1:0] smp;
  } ring_cmd_t;

  typedef struct {
    logic [1:0]        status;
    logic [DATA_W-1:0] sample;
    logic              last;
    logic [CAP_W-1:0]  avail;
  } ring_beat_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic [1:0]        command_i   = '0;
  logic [DATA_W-1:0] sample_in_i = '0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_index_i = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata_i = '0;
  logic              busy;
  logic              done_o;
  logic [1:0]        status_o;
  logic [DATA_W-1:0] sample_out_o;
  logic              last_o;
  logic [CAP_W-1:0]  frames_available_o;

  frame_ring_buffer_drop_oldest_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .command_i          (command_i),
    .sample_in_i        (sample_in_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .sample_out_o       (sample_out_o),
    .last_o             (last_o),
    .frames_available_o (frames_available_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the ring
  logic [DATA_W-1:0] ring_mem [MEM_DEPTH];
  ring_ptr_t         wr_ptr;
  ring_ptr_t         rd_ptr;
  logic [LEN_W-1:0]  wr_off;
  logic [CAP_W-1:0]  stored;
  logic [LEN_W-1:0]  len_reg;
  logic [CAP_W-1:0]  cap_reg;

  ring_cmd_t  cmd_backlog [$];
  ring_beat_t beats_due [$];
  ring_cmd_t  next_cmd;
  ring_beat_t got_beat;
  int         cmds_queued   = 0;
  int         cmds_accepted = 0;
  int         mismatch_count = 0;
  int         stall_cycles  = 0;
  int         gap_left      = 0;
  int         gap_ceiling   = 0;
  logic       cmd_taken     = 1'b0;

  function automatic logic [LEN_W-1:0] frame_len_now();
    if (len_reg == '0) return LEN_W'(1);
    if (int'(len_reg) > MAX_FRAME_LEN) return LEN_W'(MAX_FRAME_LEN);
    return len_reg;
  endfunction

  function automatic logic [CAP_W-1:0] slots_now();
    if (cap_reg == '0) return CAP_W'(1);
    if (int'(cap_reg) > MAX_SLOTS) return CAP_W'(MAX_SLOTS);
    return cap_reg;
  endfunction

  // Move a pointer one frame slot on, back to the origin past the last slot
  function automatic ring_ptr_t step_ptr(ring_ptr_t p);
    ring_ptr_t q;
    if (int'(p.slot) + 1 >= int'(slots_now())) begin
      q = '0;
    end else begin
      q.slot = p.slot + 1'b1;
      q.base = p.base + ADDR_W'(frame_len_now());
    end
    return q;
  endfunction

  function automatic void clear_ring();
    wr_ptr = '0;
    rd_ptr = '0;
    wr_off = '0;
    stored = '0;
  endfunction

  function automatic void push_beat(logic [1:0] status, logic [DATA_W-1:0] sample,
                                    logic last);
    ring_beat_t b;
    b.status = status;
    b.sample = sample;
    b.last   = last;
    b.avail  = stored;
    beats_due.push_back(b);
  endfunction

  function automatic void ring_apply_register(logic idx, logic [CAP_W-1:0] val);
    if (idx == CFG_FRAME_LEN) begin
      len_reg = val[LEN_W-1:0];
    end else begin
      cap_reg = val;
    end
    clear_ring();
  endfunction

  // Update the shadow ring for one command and queue the beats it yields
  function automatic void ring_apply_command(logic [1:0] cmd, logic [DATA_W-1:0] smp);
    logic [1:0]        status;
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  n;
    status = STAT_OK;
    n = frame_len_now();
    case (cmd)
      CMD_WRITE: begin
        // Drop the oldest frame when a new one starts on a full ring
        if (wr_off == '0 && stored >= slots_now()) begin
          rd_ptr = step_ptr(rd_ptr);
          stored = stored - 1'b1;
          status = STAT_DROP;
        end
        ring_mem[wr_ptr.base + ADDR_W'(wr_off)] = smp;
        wr_off = wr_off + 1'b1;
        if (wr_off >= n) begin
          wr_off = '0;
          wr_ptr = step_ptr(wr_ptr);
          stored = stored + 1'b1;
        end
        push_beat(status, '0, 1'b1);
      end
      CMD_READ: begin
        if (stored == '0) begin
          push_beat(STAT_EMPTY, '0, 1'b1);
        end else begin
          base = rd_ptr.base;
          rd_ptr = step_ptr(rd_ptr);
          stored = stored - 1'b1;
          for (int i = 0; i < int'(n); i++) begin
            push_beat(STAT_OK, ring_mem[base + ADDR_W'(i)], i == int'(n) - 1);
          end
        end
      end
      CMD_FLUSH: begin
        clear_ring();
        push_beat(STAT_OK, '0, 1'b1);
      end
      default: begin
        push_beat(STAT_OK, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // Monitor: check result beats, track input and register beats, watch for hangs
  always @(posedge clk_i) begin
    cmd_taken <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (done_o) begin
        if (beats_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual status %h sample %h",
                   $time, status_o, sample_out_o);
        end else begin
          got_beat = beats_due.pop_front();
          check_field("status", DATA_W'(got_beat.status), DATA_W'(status_o));
          check_field("sample_out", got_beat.sample, sample_out_o);
          check_field("last", DATA_W'(got_beat.last), DATA_W'(last_o));
          check_field("frames_available", DATA_W'(got_beat.avail),
                      DATA_W'(frames_available_o));
        end
      end
      if (cfg_we_i) begin
        ring_apply_register(cfg_index_i, cfg_wdata_i);
      end
      if (start && !busy) begin
        ring_apply_command(command_i, sample_in_i);
        cmds_accepted++;
      end
      if ((start && !busy) || cfg_we_i) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Driver: launch the next command once the bus is free and the gap has run out
  always @(negedge clk_i) begin
    if (rst_ni && (cmd_taken || !start)) begin
      if (gap_left == 0 && cmd_backlog.size() != 0) begin
        next_cmd = cmd_backlog.pop_front();
        start       <= 1'b1;
        command_i   <= next_cmd.cmd;
        sample_in_i <= next_cmd.smp;
        gap_left = $urandom_range(0, gap_ceiling);
      end else begin
        start <= 1'b0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  task automatic queue_cmd(input logic [1:0] cmd, input logic [DATA_W-1:0] smp);
    ring_cmd_t c;
    c.cmd = cmd;
    c.smp = smp;
    cmd_backlog.push_back(c);
    cmds_queued++;
  endtask

  task automatic write_reg(input logic idx, input logic [CAP_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Hold until every command is taken and every beat has come back
  task automatic wait_drained(input int settle);
    do @(negedge clk_i);
    while (cmds_accepted != cmds_queued || beats_due.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  // Mostly whole frames, with reads, partial frames, flushes and spare commands mixed in
  task automatic fill_random(input int n_cmds, input int flen);
    int made;
    int pick;
    int cnt;
    made = 0;
    while (made < n_cmds) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        cnt = flen;
      end else if (pick < 63) begin
        cnt = $urandom_range(1, flen);
      end else begin
        cnt = 1;
      end
      // stop at the requested count
      if (cnt > n_cmds - made) cnt = n_cmds - made;
      for (int i = 0; i < cnt; i++) begin
        if (pick < 63) queue_cmd(CMD_WRITE, $urandom());
        else if (pick < 88) queue_cmd(CMD_READ, $urandom());
        else if (pick < 94) queue_cmd(CMD_FLUSH, $urandom());
        else queue_cmd(CMD_SPARE, $urandom());
      end
      made += cnt;
    end
  endtask

  task automatic run_phase(input int len, input int cap, input int n_cmds, input int ceil);
    int flen;
    flen = (len == 0) ? 1 : ((len > MAX_FRAME_LEN) ? MAX_FRAME_LEN : len);
    write_reg(CFG_FRAME_LEN, CAP_W'(len));
    write_reg(CFG_CAPACITY, CAP_W'(cap));
    @(posedge clk_i);
    gap_ceiling = ceil;
    fill_random(n_cmds, flen);
    wait_drained(4);
  endtask

  initial begin
    len_reg = LEN_W'(MAX_FRAME_LEN);
    cap_reg = CAP_W'(64);
    clear_ring();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: empty read, spare command, partial frame cleared by flush
    @(posedge clk_i);
    gap_ceiling = 0;
    queue_cmd(CMD_READ, '0);
    queue_cmd(CMD_SPARE, '1);
    queue_cmd(CMD_WRITE, 32'h0000_0000);
    queue_cmd(CMD_WRITE, 32'hFFFF_FFFF);
    queue_cmd(CMD_FLUSH, 32'hFFFF_FFFF);
    queue_cmd(CMD_READ, '1);
    wait_drained(4);

    // Two-sample frames in a one-slot ring: commit, drop, read, empty, flush
    write_reg(CFG_FRAME_LEN, CAP_W'(2));
    write_reg(CFG_CAPACITY, CAP_W'(1));
    @(posedge clk_i);
    queue_cmd(CMD_WRITE, 32'h0000_0000);
    queue_cmd(CMD_WRITE, 32'hFFFF_FFFF);
    queue_cmd(CMD_WRITE, 32'hA5A5_A5A5);
    queue_cmd(CMD_WRITE, 32'h5A5A_5A5A);
    queue_cmd(CMD_READ, '0);
    queue_cmd(CMD_READ, '0);
    queue_cmd(CMD_WRITE, 32'h1234_5678);
    queue_cmd(CMD_WRITE, 32'h8765_4321);
    queue_cmd(CMD_SPARE, '1);
    queue_cmd(CMD_FLUSH, '0);
    queue_cmd(CMD_READ, '0);
    wait_drained(4);

    // Random part across several geometries, clamped extremes included
    run_phase(1, 1, 40, 11);
    run_phase(0, 0, 30, 0);
    run_phase(3, 2, 45, 11);
    run_phase(5, 4, 45, 11);
    run_phase(2, 8191, 35, 0);
    run_phase(127, 1, 80, 11);
    run_phase(7, 4096, 30, 11);
    run_phase(4, 3, 50, 0);

    wait_drained(DRAIN_WAIT);
    if (mismatch_count == 0 && beats_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
